[rtl/core/table_interpolation_and_inverse_defines.svh]
// assertion macros for the table interpolation block
// used by the top level only
`ifndef TABLE_INTERPOLATION_AND_INVERSE_DEFINES_SVH
`define TABLE_INTERPOLATION_AND_INVERSE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define TIA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent must hold in the cycle after the antecedent
`define TIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tia_pkg.sv]
// shared types and constants for the table interpolation block
// no dependencies
`timescale 1ns / 1ps

package tia_pkg;

    localparam int FRAC_BITS_DEF     = 8;
    localparam int TABLE_ENTRIES_DEF = 129;
    localparam logic signed [23:0] CODE_MAX = 24'sd32767;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_FWD  = 2'd1,
        OP_INV  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRD0,
        ST_FRD1,
        ST_FMUL,
        ST_SRD,
        ST_SCMP,
        ST_IRD,
        ST_IMUL,
        ST_IDIV,
        ST_DONE
    } state_t;

    // controller commands to datapath
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic fwd_rd0;
        logic fwd_rd1;
        logic fwd_calc;
        logic srch_rd;
        logic srch_cmp;
        logic inv_rd;
        logic inv_calc;
        logic div_start;
        logic div_step;
        logic finish;
    } cmd_t;

    // datapath status to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       srch_done;
        logic       div_done;
    } stat_t;

endpackage

[rtl/core/tia_ram.sv]
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tia_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 129
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/core/tia_ctrl.sv]
// controller state machine for the table interpolation block
// depends on tia_pkg
`timescale 1ns / 1ps

module tia_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  tia_pkg::stat_t stat,
    output tia_pkg::cmd_t  cmd,
    output logic           busy
);

    tia_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tia_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tia_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tia_pkg::ST_FRD0;
                end
            end
            tia_pkg::ST_FRD0:
            begin
                case (stat.opcode)
                    tia_pkg::OP_FWD: state_next = tia_pkg::ST_FRD1;
                    tia_pkg::OP_INV: state_next = tia_pkg::ST_SRD;
                    default:         state_next = tia_pkg::ST_DONE;
                endcase
            end
            tia_pkg::ST_FRD1: state_next = tia_pkg::ST_FMUL;
            tia_pkg::ST_FMUL: state_next = tia_pkg::ST_DONE;
            tia_pkg::ST_SRD:
            begin
                state_next = stat.srch_done ? tia_pkg::ST_IRD : tia_pkg::ST_SCMP;
            end
            tia_pkg::ST_SCMP: state_next = tia_pkg::ST_SRD;
            tia_pkg::ST_IRD:  state_next = tia_pkg::ST_IMUL;
            tia_pkg::ST_IMUL: state_next = tia_pkg::ST_IDIV;
            tia_pkg::ST_IDIV:
            begin
                if (stat.div_done)
                begin
                    state_next = tia_pkg::ST_DONE;
                end
            end
            tia_pkg::ST_DONE: state_next = tia_pkg::ST_IDLE;
            default:          state_next = tia_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        busy = (state_reg != tia_pkg::ST_IDLE);
        case (state_reg)
            tia_pkg::ST_IDLE: cmd.capture = start;
            tia_pkg::ST_FRD0:
            begin
                cmd.load_wr = (stat.opcode == tia_pkg::OP_LOAD);
                cmd.fwd_rd0 = (stat.opcode == tia_pkg::OP_FWD);
            end
            tia_pkg::ST_FRD1: cmd.fwd_rd1 = 1'b1;
            tia_pkg::ST_FMUL: cmd.fwd_calc = 1'b1;
            tia_pkg::ST_SRD:  cmd.srch_rd = 1'b1;
            tia_pkg::ST_SCMP: cmd.srch_cmp = 1'b1;
            tia_pkg::ST_IRD:  cmd.inv_rd = 1'b1;
            tia_pkg::ST_IMUL:
            begin
                cmd.inv_calc = 1'b1;
                cmd.div_start = 1'b1;
            end
            tia_pkg::ST_IDIV: cmd.div_step = 1'b1;
            tia_pkg::ST_DONE: cmd.finish = 1'b1;
            default:          cmd = '0;
        endcase
    end

endmodule

[rtl/core/tia_dp.sv]
// datapath: table ram, forward interpolation, search and serial divider
// depends on tia_pkg and tia_ram
`timescale 1ns / 1ps

module tia_dp #(
    parameter int FRAC_BITS     = tia_pkg::FRAC_BITS_DEF,
    parameter int TABLE_ENTRIES = tia_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tia_pkg::cmd_t       cmd,
    input  logic [1:0]          opcode,
    input  logic [7:0]          entry_index,
    input  logic signed [15:0]  value,
    output tia_pkg::stat_t      stat,
    output logic signed [15:0]  result,
    output logic                done
);

    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int IW  = AW + 1;
    localparam int LAST = TABLE_ENTRIES - 1;
    // numerator magnitude bits: index * 17-bit span, shifted, plus half
    localparam int NW  = IW + 18 + FRAC_BITS + 1;
    localparam int DW  = 18;
    localparam int CW  = $clog2(NW + 1);
    localparam logic [FRAC_BITS:0] SCALE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [1:0]         op_reg;
    logic [7:0]         idx_reg;
    logic signed [15:0] val_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            idx_reg <= entry_index;
            val_reg <= value;
        end
    end

    // forward operands
    logic [14:0] pcode;
    logic [14-FRAC_BITS:0] o_full;
    logic [FRAC_BITS-1:0] frac;
    assign pcode  = val_reg[15] ? 15'd0 : val_reg[14:0];
    assign o_full = pcode[14:FRAC_BITS];
    assign frac   = pcode[FRAC_BITS-1:0];

    function automatic logic [AW-1:0] sat_idx(input logic [15:0] i);
        if (i >= 16'(LAST))
        begin
            sat_idx = AW'(LAST);
        end
        else
        begin
            sat_idx = i[AW-1:0];
        end
    endfunction

    // search registers
    logic [IW-1:0] lo_reg, hi_reg;
    logic [IW:0]   mid_sum;
    logic [IW-1:0] mid;
    logic          span_one;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[IW:1];
    assign span_one = (hi_reg - lo_reg) == IW'(1);

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_rdata;
    assign ram_we = cmd.load_wr && ({8'd0, idx_reg} < 16'(TABLE_ENTRIES));

    always_comb
    begin
        ram_addr = idx_reg[AW-1:0];
        if (cmd.fwd_rd0)
        begin
            ram_addr = sat_idx(16'(o_full));
        end
        else if (cmd.fwd_rd1)
        begin
            ram_addr = sat_idx(16'(o_full) + 16'd1);
        end
        else if (cmd.srch_rd)
        begin
            ram_addr = mid[AW-1:0];
        end
        else if (cmd.inv_rd)
        begin
            ram_addr = hi_reg[AW-1:0];
        end
        else if (cmd.load_wr)
        begin
            ram_addr = idx_reg[AW-1:0];
        end
    end

    tia_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (val_reg),
        .rdata (ram_rdata)
    );

    // t0 holds the forward lower entry, tl the low entry of the bracket
    logic signed [15:0] t0_reg, tl_reg;
    logic               below;
    assign below = $signed(ram_rdata) < val_reg;

    // search state: a halving compare moves lo or hi; once the bracket is
    // one step wide, mid equals lo and the compare only latches the low entry
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lo_reg <= '0;
            hi_reg <= IW'(LAST);
        end
        else if (cmd.srch_cmp)
        begin
            if (span_one)
            begin
                tl_reg <= $signed(ram_rdata);
            end
            else if (below)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid;
                tl_reg <= $signed(ram_rdata);
            end
        end
        if (cmd.fwd_rd1)
        begin
            t0_reg <= $signed(ram_rdata);
        end
    end

    // track whether tl holds the entry at lo
    logic tl_ok_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                tl_ok_reg <= 1'b0;
            end
            else if (cmd.srch_cmp && (span_one || !below))
            begin
                tl_ok_reg <= 1'b1;
            end
        end
    end

    // search ends when hi-lo is one and the low entry is known
    assign stat.srch_done = span_one && tl_ok_reg;
    assign stat.opcode = op_reg;

    // forward product: lower * (scale-f) + upper * f
    logic signed [FRAC_BITS+1:0] wlo, whi;
    logic signed [FRAC_BITS+18:0] fprod0, fprod1, fwd_acc;
    assign wlo = $signed({1'b0, SCALE - {1'b0, frac}});
    assign whi = $signed({2'b0, frac});
    assign fprod0  = t0_reg * wlo;
    assign fprod1  = $signed(ram_rdata) * whi;
    assign fwd_acc = fprod0 + fprod1 + $signed((FRAC_BITS+19)'(SCALE >> 1));

    // inverse: numerator and divider
    logic signed [17:0] span, sub;
    assign span = 18'(tl_reg) - 18'($signed(ram_rdata));
    assign sub  = 18'(tl_reg) - 18'(val_reg);

    logic signed [NW:0]    num_w;
    logic signed [IW+1:0]  lo_s;
    logic signed [IW+19:0] lprod;
    assign lo_s  = $signed({2'b0, lo_reg});
    assign lprod = lo_s * span;
    // l*(span-sub) + h*sub = l*span + sub  since h = l+1
    assign num_w = ((NW+1)'(lprod) + (NW+1)'(sub)) <<< FRAC_BITS;

    logic [NW-1:0]  dq_reg;
    logic [NW:0]    rem_reg;
    logic [DW-1:0]  dv_reg;
    logic           neg_reg, zspan_reg;
    logic [CW-1:0]  cnt_reg;
    logic [IW-1:0]  zl_reg;
    logic           div_end;

    logic [NW:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg[NW-1:0], dq_reg[NW-1]};
    assign rem_sub = rem_sh - (NW+1)'(dv_reg);
    assign div_end = (cnt_reg == CW'(NW));

    always_ff @(posedge clk)
    begin
        if (cmd.inv_calc)
        begin
            logic signed [NW:0] half, n;
            logic [DW-1:0] aspan;
            half = (span >= 0) ? (NW+1)'(span >>> 1) : -(NW+1)'((-span + 18'sd1) >>> 1);
            n = num_w + half;
            aspan = (span < 0) ? DW'(-span) : DW'(span);
            neg_reg <= n[NW] ^ span[17];
            dq_reg <= n[NW] ? NW'(-n) : NW'(n);
            dv_reg <= aspan;
            rem_reg <= '0;
            zspan_reg <= (span == 18'sd0);
            zl_reg <= lo_reg;
            cnt_reg <= '0;
        end
        else if (cmd.div_step && !div_end)
        begin
            if (!rem_sub[NW])
            begin
                rem_reg <= rem_sub;
                dq_reg <= {dq_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                dq_reg <= {dq_reg[NW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + CW'(1);
        end
    end
    // quotient is final once all NW steps have registered
    assign stat.div_done = div_end;

    // result formation
    logic signed [15:0] res_reg;
    logic signed [NW:0] q_s, zq;
    assign q_s = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
    assign zq  = (NW+1)'(zl_reg) <<< FRAC_BITS;

    function automatic logic signed [15:0] clampc(input logic signed [NW:0] q);
        if (q > (NW+1)'(tia_pkg::CODE_MAX))
        begin
            clampc = 16'sd32767;
        end
        else if (q < 0)
        begin
            clampc = 16'sd0;
        end
        else
        begin
            clampc = q[15:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_reg <= '0;
        end
        else if (cmd.fwd_calc)
        begin
            res_reg <= fwd_acc[FRAC_BITS+15:FRAC_BITS];
        end
        else if (cmd.div_step && div_end)
        begin
            res_reg <= zspan_reg ? clampc(zq) : clampc(q_s);
        end
    end

    assign result = res_reg;
    assign done = cmd.finish;

endmodule

[rtl/core/table_interpolation_and_inverse.sv]
// top level of the table interpolation block
// depends on tia_pkg, tia_ctrl, tia_dp and the defines header
`timescale 1ns / 1ps
`include "table_interpolation_and_inverse_defines.svh"

// Loadable falling altitude table with forward (pressure code to altitude)
// and inverse (altitude to pressure code) linear interpolation. Issue a beat
// with start while busy is low; done is high for exactly one cycle with the
// result on result and cannot be stalled. A load writes the entry, and a
// forward conversion reads the lower and upper entries and then multiplies.
// An inverse runs a search (with one more read of the first entry when the
// search never moves its low bound), each halving a read and then a compare
// over the single table ram port, then a restoring divider with one step per
// numerator bit (36 at the default size) plus a final step forming the result.
module table_interpolation_and_inverse #(
    parameter int FRAC_BITS     = tia_pkg::FRAC_BITS_DEF,
    parameter int TABLE_ENTRIES = tia_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [7:0]         entry_index,
    input  logic signed [15:0] value,
    output logic signed [15:0] result,
    output logic               done
);

    tia_pkg::cmd_t  cmd;
    tia_pkg::stat_t stat;

    tia_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tia_dp #(.FRAC_BITS(FRAC_BITS), .TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (opcode),
        .entry_index (entry_index),
        .value       (value),
        .stat        (stat),
        .result      (result),
        .done        (done)
    );

    // commands that belong to distinct states
    logic [3:0] excl_cmd;
    assign excl_cmd = {cmd.fwd_calc, cmd.srch_cmp, cmd.div_step, cmd.finish};

    // checks
    `TIA_ASSERT(a_done_busy, !done || busy, "done outside busy")
    `TIA_ASSERT_NEXT(a_done_idle, done, !busy, "not idle after done")
    `TIA_ASSERT(a_cmd_onehot, $onehot0(excl_cmd), "cmd clash")

endmodule

[sim/tb_top.sv]
// self-checking testbench for the altitude table interpolation block
// depends on tia_pkg and table_interpolation_and_inverse
`timescale 1ns / 1ps

// holds the testbench copy of the altitude table and the queue of expected results
class alt_table_scoreboard;
    localparam int FRAC  = tia_pkg::FRAC_BITS_DEF;
    localparam int DEPTH = tia_pkg::TABLE_ENTRIES_DEF;

    logic signed [15:0] alt_tab [DEPTH];
    logic signed [15:0] pending_results [$];
    int                 errors;
    int                 checked;

    function new();
        errors  = 0;
        checked = 0;
        foreach (alt_tab[i]) alt_tab[i] = '0;
    endfunction

    // table read that saturates at the last entry
    function longint tab_rd(longint i);
        if (i >= DEPTH) i = DEPTH - 1;
        return longint'(alt_tab[i]);
    endfunction

    // pressure code to altitude
    function longint code_to_alt(longint p);
        longint scale;
        longint frac;
        longint pos;
        longint acc;
        scale = longint'(1) << FRAC;
        if (p < 0) p = 0;
        pos  = p >> FRAC;
        frac = p & (scale - 1);
        acc  = tab_rd(pos) * (scale - frac) + tab_rd(pos + 1) * frac + (scale >> 1);
        return acc >>> FRAC;
    endfunction

    // altitude to pressure code by search and rounded division
    function longint alt_to_code(longint alt);
        longint lo;
        longint hi;
        longint mid;
        longint span;
        longint sub;
        longint half;
        longint num;
        longint q;
        lo = 0;
        hi = DEPTH - 1;
        while (hi - lo != 1)
        begin
            mid = (lo + hi) >> 1;
            if (tab_rd(mid) < alt) hi = mid;
            else lo = mid;
        end
        span = tab_rd(lo) - tab_rd(hi);
        if (span == 0)
        begin
            q = lo << FRAC;
        end
        else
        begin
            sub  = tab_rd(lo) - alt;
            half = (span >= 0) ? span / 2 : -((-span + 1) / 2);
            num  = (lo * (span - sub) + hi * sub) * (longint'(1) << FRAC) + half;
            q    = num / span;
        end
        if (q > 32767) q = 32767;
        if (q < 0) q = 0;
        return q;
    endfunction

    // accepted input beat: update table, queue expected result
    function void note_beat(tia_pkg::op_t op, logic [7:0] idx, logic signed [15:0] val);
        longint r;
        r = 0;
        case (op)
            tia_pkg::OP_LOAD: if (idx < DEPTH) alt_tab[idx] = val;
            tia_pkg::OP_FWD:  r = code_to_alt(longint'(val));
            tia_pkg::OP_INV:  r = alt_to_code(longint'(val));
            default:          r = 0;
        endcase
        pending_results.push_back(r[15:0]);
    endfunction

    // result beat against the oldest expectation
    function void check_beat(logic signed [15:0] res);
        logic signed [15:0] exp_res;
        if (pending_results.size() == 0)
        begin
            $error("result beat %0d with nothing expected", res);
            errors++;
            return;
        end
        exp_res = pending_results.pop_front();
        checked++;
        if (res !== exp_res)
        begin
            $error("result mismatch: expected %0d actual %0d", exp_res, res);
            errors++;
        end
    endfunction

    function void check_drained();
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int DEPTH       = tia_pkg::TABLE_ENTRIES_DEF;
    localparam int STALL_LIMIT = 4000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [7:0]         entry_index;
    logic signed [15:0] value;
    logic signed [15:0] result;
    logic               done;

    alt_table_scoreboard sb;
    int                  idle_pct;
    int                  quiet_cycles;
    int                  beats_in;

    table_interpolation_and_inverse DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .entry_index (entry_index),
        .value       (value),
        .result      (result),
        .done        (done)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result capture
    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_beat(result);
    end

    // watchdog on cycles with no beat either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // drive one input beat; the sender idles in idle_pct of its cycles
    task automatic send_beat(tia_pkg::op_t op, logic [7:0] idx, logic signed [15:0] val);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        entry_index <= idx;
        value       <= val;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        sb.note_beat(op, idx, val);
        beats_in++;
    endtask

    // whole falling table with random slope
    task automatic load_falling(int base, int max_step);
        int cur;
        cur = base;
        for (int i = 0; i < DEPTH; i++)
        begin
            send_beat(tia_pkg::OP_LOAD, i[7:0], cur[15:0]);
            cur = cur - int'($urandom_range(1, max_step));
            if (cur < -32768) cur = -32768;
        end
    endtask

    // whole table of arbitrary values, not ordered
    task automatic load_scrambled();
        for (int i = 0; i < DEPTH; i++)
        begin
            send_beat(tia_pkg::OP_LOAD, i[7:0], 16'($urandom_range(0, 65535)));
        end
    endtask

    // random mix of beats on the current table
    task automatic random_phase(int count);
        int stop;
        int r;
        int ent;
        int v;
        stop = beats_in + count;
        while (beats_in < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                send_beat(tia_pkg::OP_LOAD, 8'($urandom_range(0, DEPTH - 1)),
                          16'($urandom_range(0, 65535)));
            end
            else if (r < 11)
            begin
                send_beat(tia_pkg::OP_LOAD, 8'($urandom_range(DEPTH, 255)),
                          16'($urandom_range(0, 65535)));
            end
            else if (r < 14)
            begin
                send_beat(tia_pkg::OP_NONE, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            end
            else if (r < 57)
            begin
                if ($urandom_range(0, 3) == 0) v = -int'($urandom_range(1, 32768));
                else v = int'($urandom_range(0, 32767));
                send_beat(tia_pkg::OP_FWD, 8'($urandom_range(0, 255)), v[15:0]);
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    ent = int'($urandom_range(0, DEPTH - 1));
                    v = int'(sb.alt_tab[ent]) + int'($urandom_range(0, 600)) - 300;
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                end
                else
                begin
                    v = int'($urandom_range(0, 65535));
                end
                send_beat(tia_pkg::OP_INV, 8'($urandom_range(0, 255)), v[15:0]);
            end
        end
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = tia_pkg::OP_LOAD;
        entry_index  = '0;
        value        = '0;
        quiet_cycles = 0;
        beats_in     = 0;
        idle_pct     = 20;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // flat table: every bracket has zero span
        for (int i = 0; i < DEPTH; i++) send_beat(tia_pkg::OP_LOAD, i[7:0], 16'sd1000);
        send_beat(tia_pkg::OP_INV, 8'd0, 16'sd1000);
        send_beat(tia_pkg::OP_INV, 8'd0, 16'sd999);
        send_beat(tia_pkg::OP_INV, 8'd0, 16'sd1001);

        // steep falling table spanning the full altitude range
        load_falling(32767, 511);
        send_beat(tia_pkg::OP_LOAD, 8'(DEPTH - 1), -16'sd32768);
        send_beat(tia_pkg::OP_LOAD, 8'd255, 16'sh5555);
        send_beat(tia_pkg::OP_LOAD, 8'(DEPTH), 16'shAAAA);
        send_beat(tia_pkg::OP_NONE, 8'hFF, 16'shFFFF);
        send_beat(tia_pkg::OP_FWD, 8'd0, -16'sd32768);
        send_beat(tia_pkg::OP_FWD, 8'd0, -16'sd1);
        send_beat(tia_pkg::OP_FWD, 8'd0, 16'sd0);
        send_beat(tia_pkg::OP_FWD, 8'd0, 16'sd128);
        send_beat(tia_pkg::OP_FWD, 8'd0, 16'sd255);
        send_beat(tia_pkg::OP_FWD, 8'd0, 16'sd256);
        send_beat(tia_pkg::OP_FWD, 8'hFF, 16'sd32767);
        send_beat(tia_pkg::OP_FWD, 8'd0, 16'sd32640);
        send_beat(tia_pkg::OP_INV, 8'd0, 16'sd32767);
        send_beat(tia_pkg::OP_INV, 8'd0, -16'sd32768);
        send_beat(tia_pkg::OP_INV, 8'd0, sb.alt_tab[64]);
        send_beat(tia_pkg::OP_INV, 8'd0, sb.alt_tab[64] - 16'sd1);
        send_beat(tia_pkg::OP_INV, 8'd0, 16'sd0);

        // rising table: two inverse beats, the second clamped to zero, and one forward beat
        for (int i = 0; i < DEPTH; i++)
        begin
            send_beat(tia_pkg::OP_LOAD, i[7:0], 16'(i * 200 - 12000));
        end
        send_beat(tia_pkg::OP_INV, 8'd0, 16'sd100);
        send_beat(tia_pkg::OP_INV, 8'd0, -16'sd20000);
        send_beat(tia_pkg::OP_FWD, 8'd0, 16'sd5000);

        // random traffic: falling table, then scrambled table
        idle_pct = 20;
        load_falling(30000, 400);
        random_phase(100);
        idle_pct = 77;
        load_scrambled();
        random_phase(100);
        idle_pct = 0;
        random_phase(130);

        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        sb.check_drained();

        $display("%0d beats issued, %0d results checked over flat, rising, falling and",
                 beats_in, sb.checked);
        $display("scrambled tables with sender gaps of 20, 77 and 0 percent");
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
